### rtl/mlpfp_pkg.sv
// mlpfp_pkg: sizes, codes, state type and the piecewise-linear sigmoid for the
// 3-5-2 perceptron core; no dependencies
package mlpfp_pkg;

   localparam int NUM_INPUTS  = 3;
   localparam int NUM_HIDDEN  = 5;
   localparam int NUM_OUTPUTS = 2;

   localparam int IH_COUNT    = NUM_INPUTS * NUM_HIDDEN;
   localparam int STORE_DEPTH = IH_COUNT + NUM_HIDDEN * NUM_OUTPUTS;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   localparam int IN_W   = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
   localparam int HID_W  = (NUM_HIDDEN > 1) ? $clog2(NUM_HIDDEN) : 1;
   localparam int OUT_W  = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
   localparam int MAX_TERMS = (NUM_INPUTS > NUM_HIDDEN) ? NUM_INPUTS : NUM_HIDDEN;
   localparam int MAX_NEU   = (NUM_HIDDEN > NUM_OUTPUTS) ? NUM_HIDDEN : NUM_OUTPUTS;
   localparam int TERM_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int NEU_W  = (MAX_NEU > 1) ? $clog2(MAX_NEU) : 1;

   localparam int OPA_W  = 17;
   localparam int PROD_W = 33;
   localparam int ACC_W  = 40;

   // rounding shifts for Q.22 and Q.30 sums back to Q8.8
   localparam int SH_IH = 14;
   localparam int SH_HO = 22;
   localparam logic signed [ACC_W-1:0] BIAS_IH = ACC_W'(1) <<< (SH_IH - 1);
   localparam logic signed [ACC_W-1:0] BIAS_HO = ACC_W'(1) <<< (SH_HO - 1);
   localparam logic signed [ACC_W-1:0] SAT_HI  = ACC_W'(32767);
   localparam logic signed [ACC_W-1:0] SAT_LO  = -ACC_W'(32768);

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_INFER = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_ACT,
      ST_HOLD
   } mlpfp_state_type;

   // q8.8 in, unsigned q0.16 out, 1.0 saturates to all ones
   function automatic logic [15:0] plan_sigmoid(input logic signed [15:0] x);
      logic [16:0] a;
      logic [16:0] y;
      logic [16:0] r;
      a = x[15] ? 17'(-{x[15], x}) : {1'b0, x};
      if (a >= 17'd1280) begin
         y = 17'd65536;
      end else if (a >= 17'd608) begin
         y = (a << 3) + 17'd55296;
      end else if (a >= 17'd256) begin
         y = (a << 5) + 17'd40960;
      end else begin
         y = (a << 6) + 17'd32768;
      end
      r = x[15] ? 17'd65536 - y : y;
      return r[16] ? 16'hFFFF : r[15:0];
   endfunction

endpackage

### rtl/mlp_forward_pass_sigmoid_core.sv
// mlp_forward_pass_sigmoid_core: 3-5-2 fixed-point perceptron with a shared
// multiply-accumulate unit and a piecewise-linear sigmoid; uses mlpfp_pkg
//
// A load word (command 0) writes one signed Q1.14 weight into the 25-entry store
// and produces no response; an index past the store is dropped. An infer word
// (command 1) takes three Q8.8 inputs and returns one response word with two
// unsigned Q0.16 sigmoid outputs. All 25 products go through a single 17x16
// multiplier with a registered product feeding a 40-bit accumulator, one
// product per cycle; each neuron then drains the accumulator in ST_DRAIN and
// does rounding, saturation and the sigmoid in ST_ACT. After an infer word is
// taken, req_stall stays high while the sequencer steps through ST_MAC,
// ST_DRAIN and ST_ACT for each hidden and then each output neuron and on into
// ST_HOLD, so no new word is taken until that inference is done. The response
// is registered so the next word can be taken while it waits; a response still
// stalled at the end of an inference holds req_stall high until it leaves. The
// weight store clears to zero on reset.
module mlp_forward_pass_sigmoid_core
   import mlpfp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_command,
   input  logic [4:0]         req_weight_index,
   input  logic signed [15:0] req_weight_value,
   input  logic signed [15:0] req_in_x,
   input  logic signed [15:0] req_in_y,
   input  logic signed [15:0] req_in_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_out_first,
   output logic [15:0]        rsp_out_second
);

   mlpfp_state_type state_ff, state_in;

   logic signed [15:0]       ws_ff [STORE_DEPTH];
   logic                     ws_we;
   logic [ADDR_W-1:0]        ws_waddr;

   logic signed [15:0]       x_ff  [NUM_INPUTS];
   logic signed [15:0]       x_in  [NUM_INPUTS];
   logic [15:0]              hid_ff [NUM_HIDDEN];
   logic [15:0]              hid_in [NUM_HIDDEN];
   logic [15:0]              res_ff [NUM_OUTPUTS];
   logic [15:0]              res_in [NUM_OUTPUTS];

   logic                     layer_ff, layer_in;
   logic [TERM_W-1:0]        term_ff, term_in;
   logic [NEU_W-1:0]         neuron_ff, neuron_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     prod_vld_ff, prod_vld_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [15:0]              rsp_first_ff, rsp_first_in;
   logic [15:0]              rsp_second_ff, rsp_second_in;

   logic                     req_take;
   logic                     slot_free;
   logic                     term_last;
   logic                     neuron_last;
   logic [ADDR_W-1:0]        rd_addr;
   logic signed [OPA_W-1:0]  op_a;
   logic signed [15:0]       op_b;
   logic signed [ACC_W-1:0]  shifted;
   logic signed [15:0]       pre_act;
   logic [15:0]              act;

   assign req_stall      = (state_ff != ST_IDLE);
   assign req_take       = req_valid && !req_stall;
   assign slot_free      = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_first  = rsp_first_ff;
   assign rsp_out_second = rsp_second_ff;

   assign term_last   = layer_ff ? (term_ff == TERM_W'(NUM_HIDDEN - 1))
                                 : (term_ff == TERM_W'(NUM_INPUTS - 1));
   assign neuron_last = layer_ff ? (neuron_ff == NEU_W'(NUM_OUTPUTS - 1))
                                 : (neuron_ff == NEU_W'(NUM_HIDDEN - 1));

   // shared multiplier operands
   always_comb begin
      if (layer_ff) begin
         rd_addr = ADDR_W'(IH_COUNT) + ADDR_W'(term_ff) * ADDR_W'(NUM_OUTPUTS)
                   + ADDR_W'(neuron_ff);
         op_a    = $signed({1'b0, hid_ff[term_ff[HID_W-1:0]]});
      end else begin
         rd_addr = ADDR_W'(term_ff) * ADDR_W'(NUM_HIDDEN) + ADDR_W'(neuron_ff);
         op_a    = OPA_W'(x_ff[term_ff[IN_W-1:0]]);
      end
      op_b    = ws_ff[rd_addr];
      prod_in = op_a * op_b;
   end

   // round, saturate to q8.8, sigmoid
   always_comb begin
      shifted = layer_ff ? (acc_ff >>> SH_HO) : (acc_ff >>> SH_IH);
      priority if (shifted > SAT_HI) begin
         pre_act = 16'sh7FFF;
      end else if (shifted < SAT_LO) begin
         pre_act = -16'sh8000;
      end else begin
         pre_act = shifted[15:0];
      end
      act = plan_sigmoid(pre_act);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && req_command == CMD_INFER) state_in = ST_MAC;
         end
         ST_MAC: begin
            if (term_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: state_in = ST_ACT;
         ST_ACT: begin
            state_in = (layer_ff && neuron_last) ? ST_HOLD : ST_MAC;
         end
         ST_HOLD: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      ws_we         = 1'b0;
      ws_waddr      = ADDR_W'(req_weight_index);
      x_in          = x_ff;
      hid_in        = hid_ff;
      res_in        = res_ff;
      layer_in      = layer_ff;
      term_in       = term_ff;
      neuron_in     = neuron_ff;
      prod_vld_in   = 1'b0;
      acc_in        = acc_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_command == CMD_LOAD) begin
                  ws_we = (32'(req_weight_index) < 32'(STORE_DEPTH));
               end else begin
                  for (int i = 0; i < NUM_INPUTS; i++) begin
                     if (i == 0)      x_in[i] = req_in_x;
                     else if (i == 1) x_in[i] = req_in_y;
                     else if (i == 2) x_in[i] = req_in_z;
                     else             x_in[i] = '0;
                  end
                  layer_in  = 1'b0;
                  term_in   = '0;
                  neuron_in = '0;
                  acc_in    = BIAS_IH;
               end
            end
         end
         ST_MAC: begin
            prod_vld_in = 1'b1;
            if (prod_vld_ff) acc_in = acc_ff + ACC_W'(prod_ff);
            if (!term_last) term_in = term_ff + TERM_W'(1);
         end
         ST_DRAIN: begin
            acc_in = acc_ff + ACC_W'(prod_ff);
         end
         ST_ACT: begin
            term_in = '0;
            if (!layer_ff) begin
               hid_in[neuron_ff[HID_W-1:0]] = act;
               if (neuron_last) begin
                  layer_in  = 1'b1;
                  neuron_in = '0;
               end else begin
                  neuron_in = neuron_ff + NEU_W'(1);
               end
            end else begin
               res_in[neuron_ff[OUT_W-1:0]] = act;
               if (!neuron_last) neuron_in = neuron_ff + NEU_W'(1);
            end
            acc_in = (!layer_ff && !neuron_last) ? BIAS_IH : BIAS_HO;
         end
         ST_HOLD: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_second_in = '0;
               for (int k = 0; k < NUM_OUTPUTS; k++) begin
                  if (k == 0) rsp_first_in  = res_ff[k];
                  if (k == 1) rsp_second_in = res_ff[k];
               end
            end
         end
         default: begin
            prod_vld_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prod_vld_ff  <= prod_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      hid_ff        <= hid_in;
      res_ff        <= res_in;
      layer_ff      <= layer_in;
      term_ff       <= term_in;
      neuron_ff     <= neuron_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
   end

   // weight store, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < STORE_DEPTH; k++) ws_ff[k] <= '0;
      end else if (ws_we) begin
         ws_ff[ws_waddr] <= req_weight_value;
      end
   end

   a_prod_in_mac: assert property (@(posedge clock) disable iff (reset)
      prod_vld_ff |-> (state_ff == ST_MAC || state_ff == ST_DRAIN))
      else $error("product pending outside accumulate states");

   a_drain_has_prod: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN |-> prod_vld_ff)
      else $error("drain cycle without a pending product");

   a_infer_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_command == CMD_INFER |=> state_ff == ST_MAC)
      else $error("infer word did not start the sequencer");

   a_rsp_from_hold: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_HOLD)
      else $error("response word raised outside hold state");

endmodule
